### rtl/ctep_pkg.sv
// ----------------------------------------------------------------------------
// ctep_pkg
// Shared types and constants for the civil time to epoch converter.
// ----------------------------------------------------------------------------
package ctep_pkg;

	localparam int YEAR_W  = 15;
	localparam int YOFF_W  = 16;
	localparam int DOY_W   = 9;
	localparam int TOD_W   = 27;
	localparam int DAYS_W  = 25;
	localparam int EPOCH_W = 49;

	// year offset that keeps the shifted year non-negative (41 eras)
	localparam logic [16:0] YEAR_BIAS     = 17'd16400;
	localparam logic [7:0]  ERA_BIAS      = 8'd41;
	localparam logic [11:0] RECIP_25      = 12'd2622;
	localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
	localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
	localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
	localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [15:0] MS_LIMIT      = 16'd61000;

	typedef struct packed {
		logic               valid;
		logic               bad;
		logic [YOFF_W-1:0]  yoff;
		logic [DOY_W-1:0]   doy;
		logic [TOD_W-1:0]   tod;
	} front_t;

	typedef struct packed {
		logic                     valid;
		logic                     bad;
		logic signed [DAYS_W-1:0] days;
		logic [TOD_W-1:0]         tod;
	} days_t;

	// days from 1 march to the first of the month, march first
	function automatic logic [DOY_W-1:0] month_offset(input logic [3:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/ctep_front.sv
// ----------------------------------------------------------------------------
// ctep_front
// First stage: range checks, shifted year, day of year and time of day.
// ----------------------------------------------------------------------------
module ctep_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        in_valid,
	input  logic signed [14:0]          year,
	input  logic [3:0]                  month,
	input  logic [4:0]                  day,
	input  logic [4:0]                  hour,
	input  logic [5:0]                  minute,
	input  logic [15:0]                 second_ms,
	output ctep_pkg::front_t            front_s1
);
	import ctep_pkg::*;

	logic              bad;
	logic              early;
	logic [16:0]       yoff_wide;
	logic [3:0]        mp;
	logic [DOY_W-1:0]  doy;
	logic [TOD_W-1:0]  tod;
	logic              valid_s1;
	logic              bad_s1;
	logic [YOFF_W-1:0] yoff_s1;
	logic [DOY_W-1:0]  doy_s1;
	logic [TOD_W-1:0]  tod_s1;

	always_comb begin
		bad = (month < 4'd1) || (month > 4'd12) || (day < 5'd1) || (hour > 5'd23) ||
			(minute > 6'd59) || (second_ms >= MS_LIMIT);
		early = (month <= 4'd2);
		yoff_wide = {year[14], year[14], year} + YEAR_BIAS - {16'd0, early};
		mp = early ? month + 4'd9 : month - 4'd3;
		doy = month_offset(mp) + {4'd0, day} - 9'd1;
		tod = {22'd0, hour} * {5'd0, MS_PER_HOUR} +
			{21'd0, minute} * {11'd0, MS_PER_MINUTE} + {11'd0, second_ms};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bad_s1  <= bad;
			yoff_s1 <= yoff_wide[YOFF_W-1:0];
			doy_s1  <= doy;
			tod_s1  <= tod;
		end
	end

	assign front_s1 = {valid_s1, bad_s1, yoff_s1, doy_s1, tod_s1};

endmodule

### rtl/ctep_days.sv
// ----------------------------------------------------------------------------
// ctep_days
// Era split and day count since 1970, over four stages.
// ----------------------------------------------------------------------------
module ctep_days (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ctep_pkg::front_t front_s1,
	output ctep_pkg::days_t  days_s5
);
	import ctep_pkg::*;

	// stage 2: era number by reciprocal of 25 on year / 16
	logic [23:0]        q_prod;
	logic               valid_s2, bad_s2;
	logic [YOFF_W-1:0]  yoff_s2;
	logic [6:0]         q_s2;
	logic [DOY_W-1:0]   doy_s2;
	logic [TOD_W-1:0]   tod_s2;

	// stage 3: year of era
	logic [YOFF_W-1:0]  yoe_full;
	logic               valid_s3, bad_s3;
	logic [8:0]         yoe_s3;
	logic [6:0]         q_s3;
	logic [DOY_W-1:0]   doy_s3;
	logic [TOD_W-1:0]   tod_s3;

	// stage 4: day of era
	logic [1:0]         cent;
	logic [17:0]        doe;
	logic               valid_s4, bad_s4;
	logic [17:0]        doe_s4;
	logic signed [7:0]  era_s4;
	logic [TOD_W-1:0]   tod_s4;

	// stage 5: days since epoch
	logic signed [DAYS_W-1:0] era_x;
	logic signed [DAYS_W-1:0] days_c;
	logic                     valid_s5, bad_s5;
	logic signed [DAYS_W-1:0] count_s5;
	logic [TOD_W-1:0]         tod_s5;

	assign q_prod   = front_s1.yoff[15:4] * RECIP_25;
	assign yoe_full = yoff_s2 - ({9'd0, q_s2} * {7'd0, YEARS_PER_ERA});

	always_comb begin
		if (yoe_s3 >= 9'd300) begin
			cent = 2'd3;
		end else if (yoe_s3 >= 9'd200) begin
			cent = 2'd2;
		end else if (yoe_s3 >= 9'd100) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
		doe = {9'd0, yoe_s3} * {9'd0, DAYS_PER_YEAR} + {11'd0, yoe_s3[8:2]} -
			{16'd0, cent} + {9'd0, doy_s3};
	end

	assign era_x  = {{(DAYS_W-8){era_s4[7]}}, era_s4};
	assign days_c = era_x * $signed({1'b0, 6'd0, DAYS_PER_ERA}) +
		$signed({7'd0, doe_s4}) - $signed({5'd0, DAYS_TO_EPOCH});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= front_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bad_s2  <= front_s1.bad;
			yoff_s2 <= front_s1.yoff;
			q_s2    <= q_prod[22:16];
			doy_s2  <= front_s1.doy;
			tod_s2  <= front_s1.tod;

			bad_s3  <= bad_s2;
			yoe_s3  <= yoe_full[8:0];
			q_s3    <= q_s2;
			doy_s3  <= doy_s2;
			tod_s3  <= tod_s2;

			bad_s4  <= bad_s3;
			doe_s4  <= doe;
			era_s4  <= $signed({1'b0, q_s3}) - $signed(ERA_BIAS);
			tod_s4  <= tod_s3;

			bad_s5   <= bad_s4;
			count_s5 <= days_c;
			tod_s5   <= tod_s4;
		end
	end

	assign days_s5 = {valid_s5, bad_s5, count_s5, tod_s5};

endmodule

### rtl/ctep_scale.sv
// ----------------------------------------------------------------------------
// ctep_scale
// Days to milliseconds, add the time of day, mask invalid items.
// ----------------------------------------------------------------------------
module ctep_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  ctep_pkg::days_t       days_s5,
	output logic                  valid_s7,
	output logic [48:0]           epoch_s7,
	output logic                  invalid_s7
);
	import ctep_pkg::*;

	logic signed [52:0]  prod;
	logic                valid_s6, bad_s6;
	logic [EPOCH_W-1:0]  prod_s6;
	logic [TOD_W-1:0]    tod_s6;
	logic [EPOCH_W-1:0]  total;

	assign prod  = days_s5.days * $signed({1'b0, MS_PER_DAY});
	assign total = prod_s6 + {{(EPOCH_W-TOD_W){1'b0}}, tod_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s6 <= days_s5.valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bad_s6     <= days_s5.bad;
			prod_s6    <= prod[EPOCH_W-1:0];
			tod_s6     <= days_s5.tod;
			epoch_s7   <= bad_s6 ? '0 : total;
			invalid_s7 <= bad_s6;
		end
	end

endmodule

### rtl/civil_time_to_epoch_top.sv
// throughput: one item per cycle, the whole pipeline holds while a finished item waits on a stalled output
// stages: checks, era split, year of era, day of era, day count, scaling, final sum
// reset: clears only the stage valid bits, no clearing pass
// ----------------------------------------------------------------------------
// civil_time_to_epoch_top
// Converts a split UTC date and time into signed epoch milliseconds.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [14:0] year,
	input  logic [3:0]         month,
	input  logic [4:0]         day,
	input  logic [4:0]         hour,
	input  logic [5:0]         minute,
	input  logic [15:0]        second_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [48:0] epoch_ms,
	output logic               invalid
);
	import ctep_pkg::*;

	logic         advance;
	front_t       front_s1;
	days_t        days_s5;
	logic         valid_s7;
	logic [48:0]  epoch_s7;
	logic         invalid_s7;

	// the pipeline moves unless a finished item waits on a stalled output
	assign advance  = !valid_s7 || !out_stall;
	assign in_stall = !advance;

	ctep_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (in_valid),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second_ms (second_ms),
		.front_s1  (front_s1)
	);

	ctep_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.front_s1 (front_s1),
		.days_s5  (days_s5)
	);

	ctep_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.days_s5    (days_s5),
		.valid_s7   (valid_s7),
		.epoch_s7   (epoch_s7),
		.invalid_s7 (invalid_s7)
	);

	assign out_valid = valid_s7;
	assign epoch_ms  = $signed(epoch_s7);
	assign invalid   = invalid_s7;

endmodule
